FILE: design/unft_pkg.sv
package unft_pkg;

    // Command codes of an input item.
    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_RESP   = 2'd2;
    localparam logic [1:0] CMD_REV    = 2'd3;

    // Result status codes.
    localparam logic [3:0] STAT_HIT       = 4'd0;
    localparam logic [3:0] STAT_NEW       = 4'd1;
    localparam logic [3:0] STAT_FULL      = 4'd2;
    localparam logic [3:0] STAT_AUX_DROP  = 4'd3;
    localparam logic [3:0] STAT_UNK_DROP  = 4'd4;
    localparam logic [3:0] STAT_TICK      = 4'd5;
    localparam logic [3:0] STAT_RESP_DONE = 4'd6;
    localparam logic [3:0] STAT_RESP_FAIL = 4'd7;
    localparam logic [3:0] STAT_REV_HIT   = 4'd8;
    localparam logic [3:0] STAT_REV_MISS  = 4'd9;

    // Configuration register indexes.
    localparam logic [2:0] REG_GATEWAY_IP       = 3'd0;
    localparam logic [2:0] REG_LOCAL_DNS_IP     = 3'd1;
    localparam logic [2:0] REG_AUX_ROUTER_IP    = 3'd2;
    localparam logic [2:0] REG_HOST_DNS_IP      = 3'd3;
    localparam logic [2:0] REG_HOST_LOOPBACK_IP = 3'd4;

    localparam logic [31:0] SUBNET_MASK       = 32'hFFFF_FF00;
    localparam logic [31:0] LOOPBACK_RESET_IP = 32'h7F00_0001;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic        has_payload;
        logic        resp_ok;
        logic [4:0]  entry_id;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [4:0]  flow_handle;
        logic [31:0] forward_ip;
        logic [31:0] out_src_ip;
        logic [31:0] out_dst_ip;
        logic [15:0] out_src_port;
        logic [15:0] out_dst_port;
        logic [47:0] out_src_mac;
        logic [47:0] out_dst_mac;
        logic        rx_pause;
        logic        send_pending;
        logic [4:0]  expired_count;
    } out_item_t;

    // Work class that the front assigns to an item.
    typedef enum logic [2:0] {
        KIND_LOOKUP,
        KIND_AUX_DROP,
        KIND_UNK_DROP,
        KIND_TICK,
        KIND_RESP,
        KIND_REV
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] fwd_ip;
        in_item_t    item;
    } work_t;

endpackage

FILE: design/unft_front.sv
module unft_front
    import unft_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        q_push,
    input  logic        q_full,
    output work_t       q_data
);

    logic [31:0] gateway_ip_reg;
    logic [31:0] local_dns_ip_reg;
    logic [31:0] aux_router_ip_reg;
    logic [31:0] host_dns_ip_reg;
    logic [31:0] host_loopback_ip_reg;
    logic        on_subnet;

    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gateway_ip_reg       <= '0;
            local_dns_ip_reg     <= '0;
            aux_router_ip_reg    <= '0;
            host_dns_ip_reg      <= '0;
            host_loopback_ip_reg <= LOOPBACK_RESET_IP;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GATEWAY_IP:       gateway_ip_reg       <= cfg_data;
                REG_LOCAL_DNS_IP:     local_dns_ip_reg     <= cfg_data;
                REG_AUX_ROUTER_IP:    aux_router_ip_reg    <= cfg_data;
                REG_HOST_DNS_IP:      host_dns_ip_reg      <= cfg_data;
                REG_HOST_LOOPBACK_IP: host_loopback_ip_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Classify the item and choose the forward destination.
    assign on_subnet = (s_data.dst_ip & SUBNET_MASK) == (gateway_ip_reg & SUBNET_MASK);

    always_comb begin
        q_data.item   = s_data;
        q_data.fwd_ip = '0;
        q_data.kind   = KIND_LOOKUP;
        unique case (s_data.cmd)
            CMD_TICK: q_data.kind = KIND_TICK;
            CMD_RESP: q_data.kind = KIND_RESP;
            CMD_REV:  q_data.kind = KIND_REV;
            default: begin
                if (!on_subnet) begin
                    q_data.fwd_ip = s_data.dst_ip;
                end else if (s_data.dst_ip == gateway_ip_reg) begin
                    q_data.fwd_ip = (host_dns_ip_reg == local_dns_ip_reg) ?
                                    gateway_ip_reg : host_loopback_ip_reg;
                end else if (s_data.dst_ip == local_dns_ip_reg) begin
                    q_data.fwd_ip = host_dns_ip_reg;
                end else if (s_data.dst_ip == aux_router_ip_reg) begin
                    q_data.kind = KIND_AUX_DROP;
                end else begin
                    q_data.kind = KIND_UNK_DROP;
                end
            end
        endcase
    end

endmodule

FILE: design/unft_queue.sv
module unft_queue
    import unft_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output work_t pop_data
);

    work_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_data  = slot_reg[rd_ptr_reg];

    // Two-entry ring between the front and the back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/unft_back.sv
module unft_back
    import unft_pkg::*;
#(
    parameter int FLOW_ENTRIES  = 16,
    parameter int MAX_AGE_TICKS = 3
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  work_t     q_data,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CW = $clog2(FLOW_ENTRIES + 1);
    localparam int AW = (MAX_AGE_TICKS > 1) ? $clog2(MAX_AGE_TICKS + 1) : 1;
    localparam logic [CW-1:0] CNT_END  = CW'(FLOW_ENTRIES);
    localparam logic [IW-1:0] IDX_LAST = IW'(FLOW_ENTRIES - 1);
    localparam logic [AW-1:0] AGE_MAX  = AW'(MAX_AGE_TICKS);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_TICK = 5'b00100,
        ST_REV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    work_t           cur_reg, cur_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pend_reg, pend_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            free_found_reg, free_found_next;
    logic [IW-1:0]   free_idx_reg, free_idx_next;
    logic [4:0]      exp_reg, exp_next;
    out_item_t       res_reg, res_next;
    logic            pause_reg, pause_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_reg, out_next;

    logic            valid_reg [FLOW_ENTRIES];
    logic            valid_next [FLOW_ENTRIES];
    logic [AW-1:0]   age_reg [FLOW_ENTRIES];
    logic [AW-1:0]   age_next [FLOW_ENTRIES];
    logic            mark_reg [FLOW_ENTRIES];
    logic            mark_next [FLOW_ENTRIES];

    logic [95:0]     tup_mem [FLOW_ENTRIES];
    logic [95:0]     mac_mem [FLOW_ENTRIES];
    logic [95:0]     rd_tup, rd_mac;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;

    logic [95:0]     key;
    logic            match;
    logic            free_now;
    logic [IW-1:0]   free_sel;
    logic [8:0]      eid_wide;
    logic [8:0]      eid_less;
    logic            eid_ok;
    logic [IW-1:0]   eid_idx;
    logic [IW-1:0]   tick_idx;

    function automatic logic [4:0] handle_of(input logic [IW-1:0] idx);
        handle_of = 5'(9'(idx) + 9'd1);
    endfunction

    assign key      = {cur_reg.item.src_ip, cur_reg.item.dst_ip,
                       cur_reg.item.src_port, cur_reg.item.dst_port};
    assign match    = pend_reg && valid_reg[idx_reg] && (rd_tup == key);
    assign free_now = free_found_reg || !valid_reg[idx_reg];
    assign free_sel = free_found_reg ? free_idx_reg : idx_reg;
    assign eid_wide = {4'd0, q_data.item.entry_id};
    assign eid_less = eid_wide - 9'd1;
    assign eid_ok   = (eid_wide != 9'd0) && (eid_wide <= 9'(FLOW_ENTRIES));
    assign eid_idx  = eid_less[IW-1:0];
    assign tick_idx = cnt_reg[IW-1:0];
    assign rd_addr  = (state_reg == ST_IDLE) ? eid_idx : cnt_reg[IW-1:0];
    assign wr_addr  = free_sel;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Table memories: one write and one registered read a cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tup_mem[wr_addr] <= key;
            mac_mem[wr_addr] <= {cur_reg.item.src_mac, cur_reg.item.dst_mac};
        end
        rd_tup <= tup_mem[rd_addr];
        rd_mac <= mac_mem[rd_addr];
    end

    // Sequencer for one item at a time.
    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        exp_next        = exp_reg;
        res_next        = res_reg;
        pause_next      = pause_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;
        valid_next      = valid_reg;
        age_next        = age_reg;
        mark_next       = mark_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                cnt_next        = '0;
                pend_next       = 1'b0;
                free_found_next = 1'b0;
                exp_next        = '0;
                res_next        = '0;
                res_next.rx_pause = pause_reg;
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cur_next = q_data;
                    case (q_data.kind)
                        KIND_LOOKUP: state_next = ST_SCAN;
                        KIND_TICK:   state_next = ST_TICK;
                        KIND_RESP: begin
                            if (q_data.item.resp_ok) begin
                                state_next = ST_SCAN;
                            end else begin
                                pause_next          = 1'b0;
                                res_next.status     = STAT_RESP_FAIL;
                                res_next.rx_pause   = 1'b0;
                                state_next          = ST_DONE;
                            end
                        end
                        KIND_REV: begin
                            idx_next = eid_idx;
                            if (eid_ok) begin
                                state_next = ST_REV;
                            end else begin
                                res_next.status = STAT_REV_MISS;
                                state_next      = ST_DONE;
                            end
                        end
                        KIND_AUX_DROP: begin
                            res_next.status = STAT_AUX_DROP;
                            state_next      = ST_DONE;
                        end
                        default: begin
                            res_next.status = STAT_UNK_DROP;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue one read a cycle and compare the entry read last cycle.
                if (cnt_reg != CNT_END) begin
                    cnt_next  = cnt_reg + CW'(1);
                    pend_next = 1'b1;
                    idx_next  = cnt_reg[IW-1:0];
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    if (!free_found_reg && !valid_reg[idx_reg]) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (match || idx_reg == IDX_LAST) begin
                        state_next = ST_DONE;
                        if (cur_reg.kind == KIND_RESP) begin
                            pause_next        = 1'b0;
                            res_next.rx_pause = 1'b0;
                            if (match) begin
                                res_next.status       = STAT_RESP_DONE;
                                res_next.flow_handle  = handle_of(idx_reg);
                                res_next.send_pending = mark_reg[idx_reg];
                                mark_next[idx_reg]    = 1'b0;
                            end else begin
                                res_next.status = STAT_RESP_FAIL;
                            end
                        end else begin
                            res_next.forward_ip = cur_reg.fwd_ip;
                            if (match) begin
                                res_next.status      = STAT_HIT;
                                res_next.flow_handle = handle_of(idx_reg);
                            end else if (free_now) begin
                                wr_en                = 1'b1;
                                valid_next[free_sel] = 1'b1;
                                age_next[free_sel]   = '0;
                                mark_next[free_sel]  = cur_reg.item.has_payload;
                                pause_next           = 1'b1;
                                res_next.rx_pause    = 1'b1;
                                res_next.status      = STAT_NEW;
                                res_next.flow_handle = handle_of(free_sel);
                            end else begin
                                res_next.status = STAT_FULL;
                            end
                        end
                    end
                end
            end
            ST_TICK: begin
                // Age one entry a cycle; an entry already at the age limit is evicted.
                cnt_next = cnt_reg + CW'(1);
                if (valid_reg[tick_idx]) begin
                    if (age_reg[tick_idx] == AGE_MAX) begin
                        valid_next[tick_idx] = 1'b0;
                        exp_next             = exp_reg + 5'd1;
                    end else begin
                        age_next[tick_idx] = age_reg[tick_idx] + AW'(1);
                    end
                end
                if (tick_idx == IDX_LAST) begin
                    res_next.status        = STAT_TICK;
                    res_next.expired_count = exp_next;
                    state_next             = ST_DONE;
                end
            end
            ST_REV: begin
                if (valid_reg[idx_reg]) begin
                    res_next.status       = STAT_REV_HIT;
                    res_next.flow_handle  = cur_reg.item.entry_id;
                    res_next.out_src_ip   = rd_tup[63:32];
                    res_next.out_dst_ip   = rd_tup[95:64];
                    res_next.out_src_port = rd_tup[15:0];
                    res_next.out_dst_port = rd_tup[31:16];
                    res_next.out_src_mac  = rd_mac[47:0];
                    res_next.out_dst_mac  = rd_mac[95:48];
                end else begin
                    res_next.status = STAT_REV_MISS;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pause_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < FLOW_ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg     <= state_next;
            pause_reg     <= pause_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        cnt_reg        <= cnt_next;
        pend_reg       <= pend_next;
        idx_reg        <= idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        exp_reg        <= exp_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
        age_reg        <= age_next;
        mark_reg       <= mark_next;
    end

endmodule

FILE: design/udp_nat_flow_table.sv
// UDP NAT session table with aging.
// Input items arrive on the s_ channel (s_valid/s_ready, payload s_data) and
// each produces exactly one result item on the m_ channel (m_valid/m_ready,
// payload m_data). Configuration registers are written on the cfg_ channel,
// which is always ready; write them only while the block is idle.
// A front stage classifies each item and picks the forward address, and a
// two-entry queue decouples it from the back sequencer that owns the table.
// The back walks the table one entry per cycle through its registered memory
// read port. The scan for a packet or successful response stops early when the
// flow is found; a tick always walks the whole table. Items are handled one at
// a time in the back; the front keeps accepting until the queue fills.
// Reset clears all flow valid bits, the pause level and the configuration,
// except the host loopback address, which resets to 127.0.0.1.
// When the receiver stalls, the result waits in the output register, the
// back holds its next result, and the queue then fills and drops s_ready.
module udp_nat_flow_table
    import unft_pkg::*;
#(
    parameter int FLOW_ENTRIES  = 16,
    parameter int MAX_AGE_TICKS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic  q_push;
    logic  q_full;
    work_t q_in;
    logic  q_pop;
    logic  q_valid;
    work_t q_out;

    unft_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_push    (q_push),
        .q_full    (q_full),
        .q_data    (q_in)
    );

    unft_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    unft_back #(
        .FLOW_ENTRIES  (FLOW_ENTRIES),
        .MAX_AGE_TICKS (MAX_AGE_TICKS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef ASSERT_OFF
    // A newly inserted flow always raises the pause.
    a_new_pauses: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STAT_NEW) |-> m_data.rx_pause)
        else $error("insert result without pause");

    // Held payload is only sent by a completed response.
    a_send_on_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.send_pending) |-> m_data.status == STAT_RESP_DONE)
        else $error("send_pending outside a response");

    // A response of either kind always releases the pause.
    a_resp_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == STAT_RESP_DONE ||
                     m_data.status == STAT_RESP_FAIL)) |-> !m_data.rx_pause)
        else $error("response left the pause raised");
`endif

endmodule
